/* hdl/stan_pkg.sv */
// shared constants, types and the arctangent table of the steering controller
`timescale 1ns / 1ps

package stan_pkg;

    // path table geometry
    localparam int PATH_DEPTH = 256;
    localparam int PATH_AW    = $clog2(PATH_DEPTH);
    localparam int SCAN_W     = $clog2(PATH_DEPTH + 1);

    // cordic sizing
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);
    localparam int CW                = 54;
    localparam int ZW                = 34;
    localparam logic signed [CW-1:0] CORDIC_START = CW'(64'sd652032874);
    localparam logic signed [CW-1:0] NORM_LIM     = CW'(64'sd562949953421312);

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WHEELBASE = 2'd0,
        REG_GAIN_K    = 2'd1,
        REG_GAIN_SOFT = 2'd2
    } t_reg_idx;

    // cordic command
    typedef struct packed {
        logic start;
        logic vector;
    } t_cordic_req;

    // arctangent of 2^-i in 2^32 units per turn
    function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(64'sd536870912);
            5'd1:    v = ZW'(64'sd316933406);
            5'd2:    v = ZW'(64'sd167458907);
            5'd3:    v = ZW'(64'sd85004756);
            5'd4:    v = ZW'(64'sd42667331);
            5'd5:    v = ZW'(64'sd21354465);
            5'd6:    v = ZW'(64'sd10680862);
            5'd7:    v = ZW'(64'sd5340245);
            5'd8:    v = ZW'(64'sd2670163);
            5'd9:    v = ZW'(64'sd1335087);
            5'd10:   v = ZW'(64'sd667544);
            5'd11:   v = ZW'(64'sd333772);
            5'd12:   v = ZW'(64'sd166886);
            5'd13:   v = ZW'(64'sd83443);
            5'd14:   v = ZW'(64'sd41721);
            5'd15:   v = ZW'(64'sd20860);
            5'd16:   v = ZW'(64'sd10430);
            5'd17:   v = ZW'(64'sd5215);
            5'd18:   v = ZW'(64'sd2607);
            5'd19:   v = ZW'(64'sd1303);
            5'd20:   v = ZW'(64'sd651);
            5'd21:   v = ZW'(64'sd325);
            5'd22:   v = ZW'(64'sd162);
            5'd23:   v = ZW'(64'sd81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/stan_cordic.sv */
// iterative cordic, rotation mode for cos/sin and vectoring mode for atan2
`timescale 1ns / 1ps

module stan_cordic import stan_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_req          i_req,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_done,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ITER
    } t_cstate;

    t_cstate              r_state;
    logic                 r_vector;
    logic                 r_done;
    logic [ITER_W-1:0]    r_iter;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] ang;
    logic                 rot_up;
    logic                 z_add;
    logic                 norm_go;

    // one micro-rotation
    always_comb begin
        xs      = r_x >>> r_iter;
        ys      = r_y >>> r_iter;
        ang     = atan_turn(5'(r_iter));
        rot_up  = r_vector ? !(r_y > 0) : (r_z >= 0);
        z_add   = r_vector ? (r_y > 0) : (r_z < 0);
        norm_go = (r_x < NORM_LIM) && (r_y < NORM_LIM) && (r_y > -NORM_LIM);
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_done   <= 1'b0;
            r_vector <= 1'b0;
            r_iter   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_x      <= i_x;
                        r_y      <= i_y;
                        r_z      <= i_z;
                        r_vector <= i_req.vector;
                        r_iter   <= '0;
                        r_state  <= i_req.vector ? C_NORM : C_ITER;
                    end
                end
                C_NORM: begin
                    // scale both operands up until one reaches the limit
                    if (norm_go) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (rot_up) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                    end
                    r_z <= z_add ? (r_z + ang) : (r_z - ang);
                    if (r_iter == ITER_W'(CORDIC_ITERATIONS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

/* hdl/stanley_steering_controller_core.sv */
// stanley lateral steering controller: path table, nearest point scan, steering math
`timescale 1ns / 1ps

// a load item writes the path table at its accept edge, one per idle cycle, no result
// a pose item keeps busy high through cordic rotation, front point, table scan of the
// path points, error terms, atan2 start, normalization, vectoring (skipped when both
// atan2 operands are zero) and finish; the result strobe follows; an empty path answers
// next cycle with busy low
// reset: register defaults, idle sequencer; path table contents undefined until loaded

module stanley_steering_controller_core import stan_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [7:0]         i_point_index,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic signed [15:0] i_point_heading,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic [15:0]        i_speed,
    input  logic [15:0]        i_target_speed,
    input  logic [8:0]         i_path_count,
    // result channel
    output logic               o_result_valid,
    output logic signed [16:0] o_steer_angle,
    output logic [15:0]        o_throttle,
    output logic [7:0]         o_target_index,
    output logic               o_path_error,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROT,
        S_FRONTX,
        S_FRONTY,
        S_FRONTD,
        S_SCAN,
        S_TGT_RD,
        S_TGT_DIFF,
        S_MUL_A,
        S_MUL_B,
        S_ERR_E,
        S_NUM,
        S_VEC_GO,
        S_VEC,
        S_FINISH
    } t_state;

    // configuration registers
    logic [11:0] r_wheelbase;
    logic [15:0] r_gain_k;
    logic [15:0] r_gain_soft;

    // path table
    logic [63:0]        r_mem [PATH_DEPTH];
    logic [63:0]        r_rd_data;
    logic [PATH_AW-1:0] rd_addr;

    // sequencer and pose registers
    t_state               r_state;
    logic signed [23:0]   r_pos_x;
    logic signed [23:0]   r_pos_y;
    logic signed [15:0]   r_yaw;
    logic [15:0]          r_speed;
    logic [15:0]          r_tspeed;
    logic [SCAN_W-1:0]    r_count;
    logic                 r_neg;
    logic signed [32:0]   r_cos;
    logic signed [32:0]   r_sin;
    logic signed [24:0]   r_fx;
    logic signed [24:0]   r_fy;
    logic signed [65:0]   r_prod;
    logic signed [65:0]   r_p1;
    logic signed [25:0]   r_dx;
    logic signed [25:0]   r_dy;
    logic signed [27:0]   r_e;
    logic signed [16:0]   r_derr;
    logic [25:0]          r_den;
    logic signed [17:0]   r_atan;

    // scan pipeline
    logic [SCAN_W-1:0]    r_scan_addr;
    logic                 r_s1_vld;
    logic [PATH_AW-1:0]   r_s1_idx;
    logic                 r_s2_vld;
    logic [PATH_AW-1:0]   r_s2_idx;
    logic signed [25:0]   r_s2_dx;
    logic signed [25:0]   r_s2_dy;
    logic                 r_s3_vld;
    logic [PATH_AW-1:0]   r_s3_idx;
    logic [50:0]          r_s3_sqx;
    logic [50:0]          r_s3_sqy;
    logic                 r_s4_vld;
    logic [PATH_AW-1:0]   r_s4_idx;
    logic [50:0]          r_s4_dist;
    logic                 r_have_best;
    logic                 r_have_sec;
    logic [PATH_AW-1:0]   r_best;
    logic [PATH_AW-1:0]   r_sec;
    logic [50:0]          r_best_d;
    logic [50:0]          r_sec_d;
    logic [PATH_AW-1:0]   r_tgt;

    // result registers
    logic                 r_valid;
    logic signed [16:0]   r_steer;
    logic [15:0]          r_throttle;
    logic [7:0]           r_tindex;
    logic                 r_perr;

    // cordic interface
    t_cordic_req          cq;
    logic signed [CW-1:0] cq_x;
    logic signed [CW-1:0] cq_y;
    logic signed [ZW-1:0] cq_z;
    logic                 cd_done;
    logic signed [CW-1:0] cd_x;
    logic signed [CW-1:0] cd_y;
    logic signed [ZW-1:0] cd_z;

    // combinational helpers
    logic                 accept;
    logic signed [ZW-1:0] z_raw;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [65:0]   mul_p;
    logic signed [65:0]   round_tmp;
    logic signed [65:0]   front_sh;
    logic signed [65:0]   e_tmp;
    logic signed [25:0]   sdx;
    logic signed [25:0]   sdy;
    logic signed [17:0]   hdiff;
    logic signed [17:0]   steer_sum;
    logic signed [ZW-1:0] z_rnd;
    logic                 scan_issue;
    logic                 scan_idle;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase <= 12'd768;
            r_gain_k    <= 16'd256;
            r_gain_soft <= 16'd256;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WHEELBASE: r_wheelbase <= pwdata[11:0];
                REG_GAIN_K:    r_gain_k    <= pwdata[15:0];
                REG_GAIN_SOFT: r_gain_soft <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        case (paddr[3:2])
            REG_WHEELBASE: prdata = {20'd0, r_wheelbase};
            REG_GAIN_K:    prdata = {16'd0, r_gain_k};
            REG_GAIN_SOFT: prdata = {16'd0, r_gain_soft};
            default:       prdata = '0;
        endcase
    end

    // path table: load writes, one registered read port
    assign rd_addr = (r_state == S_SCAN) ? r_scan_addr[PATH_AW-1:0] : r_tgt;

    always_ff @(posedge i_clk) begin
        if (accept && !i_op && (32'(i_point_index) < PATH_DEPTH)) begin
            r_mem[PATH_AW'(i_point_index)] <= {i_point_x, i_point_y, i_point_heading};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // yaw folded into the cordic range, negated afterward when folded
    always_comb begin
        z_raw = ZW'($signed({i_heading, 16'd0}));
        cq    = '0;
        cq_x  = '0;
        cq_y  = '0;
        cq_z  = '0;
        if (accept && i_op && (i_path_count != 9'd0)) begin
            cq.start = 1'b1;
            cq_x     = CORDIC_START;
            if (z_raw > ZW'(64'sd1073741824)) begin
                cq_z = z_raw - ZW'(64'sd2147483648);
            end else if (z_raw < -ZW'(64'sd1073741824)) begin
                cq_z = z_raw + ZW'(64'sd2147483648);
            end else begin
                cq_z = z_raw;
            end
        end else if (r_state == S_VEC_GO && !(r_prod == 0 && r_den == 0)) begin
            cq.start  = 1'b1;
            cq.vector = 1'b1;
            cq_x      = CW'($signed({1'b0, r_den}));
            cq_y      = r_prod[CW-1:0];
        end
    end

    stan_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cq),
        .i_x     (cq_x),
        .i_y     (cq_y),
        .i_z     (cq_z),
        .o_done  (cd_done),
        .o_x     (cd_x),
        .o_y     (cd_y),
        .o_z     (cd_z)
    );

    // shared multiplier operand selection
    always_comb begin
        case (r_state)
            S_FRONTX: begin
                mul_a = $signed({21'd0, r_wheelbase});
                mul_b = r_cos;
            end
            S_FRONTY: begin
                mul_a = $signed({21'd0, r_wheelbase});
                mul_b = r_sin;
            end
            S_MUL_A: begin
                mul_a = 33'(r_dx);
                mul_b = r_sin;
            end
            S_MUL_B: begin
                mul_a = 33'(r_dy);
                mul_b = r_cos;
            end
            default: begin
                mul_a = $signed({17'd0, r_gain_k});
                mul_b = 33'(r_e);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // rounding, differences and wrap
    always_comb begin
        round_tmp = r_prod + 66'sd1073741824;
        front_sh  = round_tmp >>> 31;
        e_tmp     = (r_p1 - r_prod + 66'sd536870912) >>> 30;
        sdx       = 26'(r_fx) - 26'($signed(r_rd_data[63:40]));
        sdy       = 26'(r_fy) - 26'($signed(r_rd_data[39:16]));
        hdiff     = 18'($signed(r_rd_data[15:0])) - 18'(r_yaw);
        z_rnd     = (cd_z + ZW'(64'sd32768)) >>> 16;
        steer_sum = 18'(r_derr) + r_atan;
        scan_issue = (r_state == S_SCAN) && (r_scan_addr < r_count);
        scan_idle  = !r_s1_vld && !r_s2_vld && !r_s3_vld && !r_s4_vld;
    end

    // scan pipeline: read, difference, square, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= scan_issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
        r_s1_idx  <= r_scan_addr[PATH_AW-1:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_dx   <= sdx;
        r_s2_dy   <= sdy;
        r_s3_idx  <= r_s2_idx;
        r_s3_sqx  <= 51'(r_s2_dx * r_s2_dx);
        r_s3_sqy  <= 51'(r_s2_dy * r_s2_dy);
        r_s4_idx  <= r_s3_idx;
        r_s4_dist <= r_s3_sqx + r_s3_sqy;
    end

    // main sequencer and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_op) begin
                        r_pos_x  <= i_pos_x;
                        r_pos_y  <= i_pos_y;
                        r_yaw    <= i_heading;
                        r_speed  <= i_speed;
                        r_tspeed <= i_target_speed;
                        r_neg    <= (z_raw > ZW'(64'sd1073741824)) ||
                                    (z_raw < -ZW'(64'sd1073741824));
                        r_count  <= (32'(i_path_count) > PATH_DEPTH) ?
                                    SCAN_W'(PATH_DEPTH) : SCAN_W'(i_path_count);
                        if (i_path_count == 9'd0) begin
                            // empty path answers at once
                            r_valid    <= 1'b1;
                            r_steer    <= '0;
                            r_throttle <= '0;
                            r_tindex   <= '0;
                            r_perr     <= 1'b1;
                        end else begin
                            r_state <= S_ROT;
                        end
                    end
                end
                S_ROT: begin
                    if (cd_done) begin
                        r_cos   <= r_neg ? -cd_x[32:0] : cd_x[32:0];
                        r_sin   <= r_neg ? -cd_y[32:0] : cd_y[32:0];
                        r_state <= S_FRONTX;
                    end
                end
                S_FRONTX: begin
                    r_prod  <= mul_p;
                    r_state <= S_FRONTY;
                end
                S_FRONTY: begin
                    r_fx    <= 25'(r_pos_x) + front_sh[24:0];
                    r_prod  <= mul_p;
                    r_state <= S_FRONTD;
                end
                S_FRONTD: begin
                    r_fy        <= 25'(r_pos_y) + front_sh[24:0];
                    r_scan_addr <= '0;
                    r_have_best <= 1'b0;
                    r_have_sec  <= 1'b0;
                    r_state     <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_scan_addr <= r_scan_addr + 1'b1;
                    end
                    // keep the two nearest, earliest index wins ties
                    if (r_s4_vld) begin
                        if (!r_have_best || r_s4_dist < r_best_d) begin
                            r_sec       <= r_best;
                            r_sec_d     <= r_best_d;
                            r_have_sec  <= r_have_best;
                            r_best      <= r_s4_idx;
                            r_best_d    <= r_s4_dist;
                            r_have_best <= 1'b1;
                        end else if (!r_have_sec || r_s4_dist < r_sec_d) begin
                            r_sec      <= r_s4_idx;
                            r_sec_d    <= r_s4_dist;
                            r_have_sec <= 1'b1;
                        end
                    end
                    if (!scan_issue && scan_idle) begin
                        r_tgt   <= (r_have_sec && r_sec > r_best) ? r_sec : r_best;
                        r_state <= S_TGT_RD;
                    end
                end
                S_TGT_RD: begin
                    r_state <= S_TGT_DIFF;
                end
                S_TGT_DIFF: begin
                    r_dx <= sdx;
                    r_dy <= sdy;
                    if (hdiff > 18'sd32768) begin
                        r_derr <= 17'(hdiff - 18'sd65536);
                    end else if (hdiff < -18'sd32768) begin
                        r_derr <= 17'(hdiff + 18'sd65536);
                    end else begin
                        r_derr <= 17'(hdiff);
                    end
                    r_den   <= 26'({1'b0, r_speed} + {1'b0, r_gain_soft}) << 8;
                    r_state <= S_MUL_A;
                end
                S_MUL_A: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_p1    <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_ERR_E;
                end
                S_ERR_E: begin
                    r_e     <= e_tmp[27:0];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_prod  <= mul_p;
                    r_state <= S_VEC_GO;
                end
                S_VEC_GO: begin
                    if (r_prod == 0 && r_den == 0) begin
                        r_atan  <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_VEC;
                    end
                end
                S_VEC: begin
                    if (cd_done) begin
                        r_atan  <= z_rnd[17:0];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_valid    <= 1'b1;
                    r_steer    <= steer_sum[16:0];
                    r_throttle <= r_tspeed;
                    r_tindex   <= 8'(r_tgt);
                    r_perr     <= 1'b0;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_valid;
    assign o_steer_angle  = r_steer;
    assign o_throttle     = r_throttle;
    assign o_target_index = r_tindex;
    assign o_path_error   = r_perr;

endmodule
